### rtl/tdnd_pkg.sv
`default_nettype none

package tdnd_pkg;

   localparam int unsigned STATE_W  = 4;
   localparam int unsigned SYMBOL_W = 8;
   localparam int unsigned INDEX_W  = 5;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned MASK_W   = 16;
   localparam int unsigned CSR_W    = 16;

   // Input modes.
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_CHAR  = 2'd1;
   localparam logic [1:0] MODE_EMPTY = 2'd2;

   // Kinds of queued word.
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FAIL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_STATE      = 2'd0;
   localparam logic [1:0] CSR_TRANSITION_COUNT = 2'd1;
   localparam logic [1:0] CSR_ACCEPT_MASK      = 2'd2;

   // Characters.
   localparam logic [7:0] CH_DIGIT_WILD = 8'h64;
   localparam logic [7:0] CH_EXP_UP     = 8'h45;
   localparam logic [7:0] CH_EXP_LO     = 8'h65;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;

   typedef struct packed {
      logic [1:0]          kind;
      logic [INDEX_W-1:0]  load_idx;
      logic [STATE_W-1:0]  from_state;
      logic [SYMBOL_W-1:0] match_symbol;
      logic [STATE_W-1:0]  to_state;
      logic [SYMBOL_W-1:0] symbol;
      logic                legal;
      logic                digit;
      logic                last;
   } item_type;

   typedef struct packed {
      logic [STATE_W-1:0] start_state;
      logic [COUNT_W-1:0] transition_count;
      logic [MASK_W-1:0]  accept_mask;
   } cfg_type;

   typedef struct packed {
      logic from_valid;
      logic to_ready;
   } qctl_type;

endpackage

`default_nettype wire

### rtl/tdnd_front.sv
`default_nettype none

module tdnd_front #(
   parameter int unsigned MAX_TRANSITIONS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_mode,
   input  logic [tdnd_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [tdnd_pkg::STATE_W-1:0]   req_from_state,
   input  logic [tdnd_pkg::SYMBOL_W-1:0]  req_match_symbol,
   input  logic [tdnd_pkg::STATE_W-1:0]   req_to_state,
   input  logic [tdnd_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic                           req_last,
   input  logic                           q_pop,
   output tdnd_pkg::qctl_type             q_ctl,
   output tdnd_pkg::item_type             q_item
);

   tdnd_pkg::item_type q_ff [0:1];
   tdnd_pkg::item_type item;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [7:0]         folded;
   logic               keep;
   logic               enq;

   always_comb begin
      folded = (req_symbol == tdnd_pkg::CH_EXP_LO) ? tdnd_pkg::CH_EXP_UP : req_symbol;
      item.kind         = req_mode;
      item.load_idx     = req_entry_index;
      item.from_state   = req_from_state;
      item.match_symbol = req_match_symbol;
      item.to_state     = req_to_state;
      item.symbol       = folded;
      item.digit        = (folded >= tdnd_pkg::CH_ZERO) && (folded <= tdnd_pkg::CH_NINE);
      item.legal        = item.digit || (folded == tdnd_pkg::CH_DOT) ||
                          (folded == tdnd_pkg::CH_EXP_UP) || (folded == tdnd_pkg::CH_PLUS) ||
                          (folded == tdnd_pkg::CH_MINUS);
      item.last         = req_last;
      case (req_mode)
         tdnd_pkg::MODE_LOAD:  keep = {4'b0, req_entry_index} < 9'(MAX_TRANSITIONS);
         tdnd_pkg::MODE_CHAR:  keep = 1'b1;
         tdnd_pkg::MODE_EMPTY: keep = 1'b1;
         default:              keep = 1'b0;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign enq       = req_valid && req_ready && keep;

   always_comb begin
      wr_ptr_in = enq   ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, enq} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_ctl.from_valid = (cnt_ff != 2'd0);
   assign q_ctl.to_ready   = req_ready;
   assign q_item           = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### rtl/tdnd_back.sv
`default_nettype none

module tdnd_back #(
   parameter int unsigned MAX_TRANSITIONS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  tdnd_pkg::cfg_type  cfg,
   input  tdnd_pkg::qctl_type q_ctl,
   input  tdnd_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic [1:0]         rsp_status
);

   localparam int unsigned IDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_TRANSITIONS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [15:0]            tbl [0:MAX_TRANSITIONS-1];
   logic [15:0]            rd_data_ff;
   logic [1:0]             st_ff, st_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   pend_ff, pend_in;
   logic [3:0]             cur_ff, cur_in;
   logic                   in_str_ff, in_str_in;
   logic                   failed_ff, failed_in;
   tdnd_pkg::item_type     item_ff, item_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_acc_ff, rsp_acc_in;
   logic [1:0]             rsp_stat_ff, rsp_stat_in;
   logic [8:0]             count_ext;
   logic [CNT_W-1:0]       limit;
   logic                   out_free;
   logic                   issue;
   logic                   mem_we;
   logic                   hit;
   logic                   fail_now;
   logic [7:0]             load_ext;

   assign count_ext = {3'b0, cfg.transition_count};
   assign limit     = (count_ext > 9'(MAX_TRANSITIONS)) ? CNT_W'(MAX_TRANSITIONS)
                                                        : CNT_W'(count_ext);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_ext  = {3'b0, q_item.load_idx};
   assign hit       = (rd_data_ff[15:12] == cur_ff) &&
                      ((rd_data_ff[11:4] == item_ff.symbol) ||
                       ((rd_data_ff[11:4] == tdnd_pkg::CH_DIGIT_WILD) && item_ff.digit));

   always_comb begin
      st_in        = st_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      cur_in       = cur_ff;
      in_str_in    = in_str_ff;
      failed_in    = failed_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_stat_in  = rsp_stat_ff;
      q_pop        = 1'b0;
      issue        = 1'b0;
      mem_we       = 1'b0;
      fail_now     = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (q_ctl.from_valid) begin
               case (q_item.kind)
                  tdnd_pkg::KIND_LOAD: begin
                     q_pop  = 1'b1;
                     mem_we = 1'b1;
                  end
                  tdnd_pkg::KIND_EMPTY: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        in_str_in    = 1'b0;
                        failed_in    = 1'b0;
                        rsp_valid_in = 1'b1;
                        rsp_acc_in   = 1'b0;
                        rsp_stat_in  = tdnd_pkg::STAT_EMPTY;
                     end
                  end
                  tdnd_pkg::KIND_CHAR: begin
                     q_pop     = 1'b1;
                     item_in   = q_item;
                     in_str_in = 1'b1;
                     if (!in_str_ff) begin
                        cur_in   = cfg.start_state;
                        fail_now = !q_item.legal;
                     end else begin
                        fail_now = failed_ff || !q_item.legal;
                     end
                     failed_in = fail_now;
                     scan_in   = '0;
                     pend_in   = 1'b0;
                     st_in     = fail_now ? ST_FINISH : ST_SCAN;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            issue   = (scan_ff < limit);
            pend_in = issue;
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (pend_ff && hit) begin
               cur_in  = rd_data_ff[3:0];
               pend_in = 1'b0;
               st_in   = ST_FINISH;
            end else if (!issue) begin
               failed_in = 1'b1;
               st_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!item_ff.last) begin
               st_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = !failed_ff && cfg.accept_mask[cur_ff];
               rsp_stat_in  = failed_ff ? tdnd_pkg::STAT_FAIL : tdnd_pkg::STAT_OK;
               in_str_in    = 1'b0;
               failed_in    = 1'b0;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         cur_ff       <= 4'd0;
         in_str_ff    <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         cur_ff       <= cur_in;
         in_str_ff    <= in_str_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl[load_ext[IDX_W-1:0]] <= {q_item.from_state, q_item.match_symbol, q_item.to_state};
      end
      if (issue) begin
         rd_data_ff <= tbl[scan_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_status   = rsp_stat_ff;

endmodule

`default_nettype wire

### rtl/table_driven_number_dfa_top.sv
`default_nettype none

// Recognises numeric strings against a transition table loaded through the
// request channel. A front stage takes one word per cycle, while the queue
// has room, into a two-entry queue, and the back stage works through the
// queue in order. For a character the back stage starts, reads the table
// entries up to the limit, which is transition_count capped at
// MAX_TRANSITIONS, one at a time from the single read port of the table
// memory with registered read data, and then finishes; it stops early when
// an entry matches and skips the reads when the character is already known
// to fail. The result register lets the back stage carry on with loads and
// characters that are not the last while a result waits to be taken.
module table_driven_number_dfa_top #(
   parameter int unsigned MAX_TRANSITIONS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_mode,
   input  logic [tdnd_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [tdnd_pkg::STATE_W-1:0]   req_from_state,
   input  logic [tdnd_pkg::SYMBOL_W-1:0]  req_match_symbol,
   input  logic [tdnd_pkg::STATE_W-1:0]   req_to_state,
   input  logic [tdnd_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [tdnd_pkg::CSR_W-1:0]     csr_wdata
);

   tdnd_pkg::cfg_type  cfg_ff;
   tdnd_pkg::cfg_type  cfg_in;
   tdnd_pkg::qctl_type q_ctl;
   tdnd_pkg::item_type q_item;
   logic               q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tdnd_pkg::CSR_START_STATE:
               cfg_in.start_state = csr_wdata[tdnd_pkg::STATE_W-1:0];
            tdnd_pkg::CSR_TRANSITION_COUNT:
               cfg_in.transition_count = csr_wdata[tdnd_pkg::COUNT_W-1:0];
            tdnd_pkg::CSR_ACCEPT_MASK:
               cfg_in.accept_mask = csr_wdata[tdnd_pkg::MASK_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tdnd_front #(
      .MAX_TRANSITIONS (MAX_TRANSITIONS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_from_state   (req_from_state),
      .req_match_symbol (req_match_symbol),
      .req_to_state     (req_to_state),
      .req_symbol       (req_symbol),
      .req_last         (req_last),
      .q_pop            (q_pop),
      .q_ctl            (q_ctl),
      .q_item           (q_item)
   );

   tdnd_back #(
      .MAX_TRANSITIONS (MAX_TRANSITIONS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_ctl        (q_ctl),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted),
      .rsp_status   (rsp_status)
   );

   // The back stage never takes a word from an empty queue.
   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_ctl.from_valid)
      else $error("queue popped while empty");

   // An accepting result always carries the good status.
   a_accept_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_status == tdnd_pkg::STAT_OK))
      else $error("accepted result with bad status");

   // A result never carries the unused status code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == tdnd_pkg::STAT_OK || rsp_status == tdnd_pkg::STAT_FAIL ||
                     rsp_status == tdnd_pkg::STAT_EMPTY))
      else $error("result with unused status");

   // A full queue holds off the request side.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      !q_ctl.to_ready |-> (q_ctl.from_valid && !req_ready))
      else $error("queue full but request side not stalled");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int TABLE_DEPTH    = 32;
   localparam int NUMBER_ENTRIES = 17;
   localparam int WORD_BUDGET    = 1500;
   localparam int CALM_WORDS     = 200;
   localparam int SETTLE_CYCLES  = 150;
   localparam logic [1:0]  MODE_UNUSED   = 2'd3;
   localparam logic [15:0] NUMBER_ACCEPT = 16'h0094;

   typedef struct packed {
      logic [1:0]                    mode;
      logic [tdnd_pkg::INDEX_W-1:0]  entry_index;
      logic [tdnd_pkg::STATE_W-1:0]  from_state;
      logic [tdnd_pkg::SYMBOL_W-1:0] match_symbol;
      logic [tdnd_pkg::STATE_W-1:0]  to_state;
      logic [tdnd_pkg::SYMBOL_W-1:0] symbol;
      logic                          last;
   } dfa_word_type;

   typedef struct packed {
      logic       accepted;
      logic [1:0] status;
   } verdict_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_mode         = '0;
   logic [tdnd_pkg::INDEX_W-1:0]  req_entry_index  = '0;
   logic [tdnd_pkg::STATE_W-1:0]  req_from_state   = '0;
   logic [tdnd_pkg::SYMBOL_W-1:0] req_match_symbol = '0;
   logic [tdnd_pkg::STATE_W-1:0]  req_to_state     = '0;
   logic [tdnd_pkg::SYMBOL_W-1:0] req_symbol       = '0;
   logic                          req_last         = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic                          rsp_accepted;
   logic [1:0]                    rsp_status;
   logic                          csr_we           = 1'b0;
   logic [1:0]                    csr_index        = '0;
   logic [tdnd_pkg::CSR_W-1:0]    csr_wdata        = '0;

   logic [15:0]                  model_table [TABLE_DEPTH];
   logic [tdnd_pkg::STATE_W-1:0] model_state     = '0;
   bit                           model_in_string = 1'b0;
   bit                           model_failed    = 1'b0;
   logic [tdnd_pkg::STATE_W-1:0] cfg_start       = '0;
   logic [tdnd_pkg::COUNT_W-1:0] cfg_count       = '0;
   logic [tdnd_pkg::MASK_W-1:0]  cfg_mask        = '0;

   verdict_type  verdicts [$];
   dfa_word_type pending [$];
   logic [7:0]   spelling [$];
   dfa_word_type held;
   verdict_type  wanted;
   bit           calm         = 1'b0;
   int           mismatches   = 0;
   int           words_queued = 0;
   int           idle_left    = 0;
   int           stall_left   = 0;

   table_driven_number_dfa_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_from_state   (req_from_state),
      .req_match_symbol (req_match_symbol),
      .req_to_state     (req_to_state),
      .req_symbol       (req_symbol),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit is_digit(input logic [7:0] ch);
      return ch >= tdnd_pkg::CH_ZERO && ch <= tdnd_pkg::CH_NINE;
   endfunction

   function automatic bit lookup_next_state(input logic [tdnd_pkg::STATE_W-1:0] st,
                                            input logic [7:0] ch,
                                            output logic [tdnd_pkg::STATE_W-1:0] nx);
      int          limit;
      logic [15:0] e;
      limit = (int'(cfg_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
      nx = st;
      for (int i = 0; i < limit; i++) begin
         e = model_table[i];
         if (e[15:12] == st &&
             (e[11:4] == ch || (e[11:4] == tdnd_pkg::CH_DIGIT_WILD && is_digit(ch)))) begin
            nx = e[3:0];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void step_recogniser(input dfa_word_type w);
      logic [7:0]                   ch;
      logic [tdnd_pkg::STATE_W-1:0] nx;
      verdict_type                  v;
      case (w.mode)
         tdnd_pkg::MODE_LOAD: begin
            model_table[w.entry_index] = {w.from_state, w.match_symbol, w.to_state};
         end
         tdnd_pkg::MODE_EMPTY: begin
            model_in_string = 1'b0;
            model_failed = 1'b0;
            v.accepted = 1'b0;
            v.status = tdnd_pkg::STAT_EMPTY;
            verdicts.push_back(v);
         end
         tdnd_pkg::MODE_CHAR: begin
            if (!model_in_string) begin
               model_in_string = 1'b1;
               model_failed = 1'b0;
               model_state = cfg_start;
            end
            if (!model_failed) begin
               ch = (w.symbol == tdnd_pkg::CH_EXP_LO) ? tdnd_pkg::CH_EXP_UP : w.symbol;
               if (!(is_digit(ch) || ch == tdnd_pkg::CH_DOT || ch == tdnd_pkg::CH_EXP_UP ||
                     ch == tdnd_pkg::CH_PLUS || ch == tdnd_pkg::CH_MINUS))
                  model_failed = 1'b1;
               else if (lookup_next_state(model_state, ch, nx))
                  model_state = nx;
               else
                  model_failed = 1'b1;
            end
            if (w.last) begin
               v.accepted = !model_failed && cfg_mask[model_state];
               v.status = model_failed ? tdnd_pkg::STAT_FAIL : tdnd_pkg::STAT_OK;
               verdicts.push_back(v);
               model_in_string = 1'b0;
               model_failed = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // A new word is presented only once the one held has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && req_ready)
            step_recogniser(held);
         if (!req_valid || req_ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               idle_left = $urandom_range(0, 8);
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               held = pending.pop_front();
               req_valid <= 1'b1;
               req_mode <= held.mode;
               req_entry_index <= held.entry_index;
               req_from_state <= held.from_state;
               req_match_symbol <= held.match_symbol;
               req_to_state <= held.to_state;
               req_symbol <= held.symbol;
               req_last <= held.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected result accepted %0b status %0d",
                                         rsp_accepted, rsp_status));
            end else begin
               wanted = verdicts.pop_front();
               if (rsp_accepted !== wanted.accepted)
                  report_mismatch($sformatf("accepted %b, expected %b",
                                            rsp_accepted, wanted.accepted));
               if (rsp_status !== wanted.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, wanted.status));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [15:0] number_entry(input int slot);
      case (slot)
         0:       return {4'd0, tdnd_pkg::CH_PLUS, 4'd1};
         1:       return {4'd0, tdnd_pkg::CH_MINUS, 4'd1};
         2:       return {4'd0, tdnd_pkg::CH_DIGIT_WILD, 4'd2};
         3:       return {4'd0, tdnd_pkg::CH_DOT, 4'd3};
         4:       return {4'd1, tdnd_pkg::CH_DIGIT_WILD, 4'd2};
         5:       return {4'd1, tdnd_pkg::CH_DOT, 4'd3};
         6:       return {4'd2, tdnd_pkg::CH_DIGIT_WILD, 4'd2};
         7:       return {4'd2, tdnd_pkg::CH_DOT, 4'd4};
         8:       return {4'd2, tdnd_pkg::CH_EXP_UP, 4'd5};
         9:       return {4'd3, tdnd_pkg::CH_DIGIT_WILD, 4'd4};
         10:      return {4'd4, tdnd_pkg::CH_DIGIT_WILD, 4'd4};
         11:      return {4'd4, tdnd_pkg::CH_EXP_UP, 4'd5};
         12:      return {4'd5, tdnd_pkg::CH_PLUS, 4'd6};
         13:      return {4'd5, tdnd_pkg::CH_MINUS, 4'd6};
         14:      return {4'd5, tdnd_pkg::CH_DIGIT_WILD, 4'd7};
         15:      return {4'd6, tdnd_pkg::CH_DIGIT_WILD, 4'd7};
         default: return {4'd7, tdnd_pkg::CH_DIGIT_WILD, 4'd7};
      endcase
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return tdnd_pkg::CH_ZERO + 8'($urandom_range(0, 9));
         4:          return tdnd_pkg::CH_DOT;
         5:          return tdnd_pkg::CH_EXP_UP;
         6:          return tdnd_pkg::CH_EXP_LO;
         7:          return tdnd_pkg::CH_PLUS;
         8:          return tdnd_pkg::CH_MINUS;
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] random_entry(input int top_state);
      logic [3:0] from, to;
      logic [7:0] sym;
      from = 4'($urandom_range(0, top_state));
      to = 4'($urandom_range(0, top_state));
      sym = ($urandom_range(0, 2) == 0) ? tdnd_pkg::CH_DIGIT_WILD : pick_char();
      return {from, sym, to};
   endfunction

   task automatic push_word(input dfa_word_type w);
      pending.push_back(w);
      if (w.mode != MODE_UNUSED)
         words_queued++;
   endtask

   task automatic push_load(input int slot, input logic [15:0] entry);
      dfa_word_type w;
      w = $urandom;
      w.mode = tdnd_pkg::MODE_LOAD;
      w.entry_index = 5'(slot);
      w.from_state = entry[15:12];
      w.match_symbol = entry[11:4];
      w.to_state = entry[3:0];
      push_word(w);
   endtask

   task automatic push_char(input logic [7:0] ch, input bit fin);
      dfa_word_type w;
      w = $urandom;
      w.mode = tdnd_pkg::MODE_CHAR;
      w.symbol = ch;
      w.last = fin;
      push_word(w);
   endtask

   task automatic push_empty();
      dfa_word_type w;
      w = $urandom;
      w.mode = tdnd_pkg::MODE_EMPTY;
      push_word(w);
   endtask

   task automatic push_noise();
      dfa_word_type w;
      w = $urandom;
      w.mode = MODE_UNUSED;
      push_word(w);
   endtask

   task automatic push_spelling(input int upto, input bit terminate);
      for (int i = 1; i <= upto; i++)
         push_char(spelling.pop_front(), terminate && i == upto);
   endtask

   task automatic push_text(input string s, input bit terminate);
      spelling.delete();
      for (int i = 0; i < s.len(); i++)
         spelling.push_back(s[i]);
      push_spelling(spelling.size(), terminate);
   endtask

   task automatic add_digits(input int lo, input int hi);
      repeat ($urandom_range(lo, hi))
         spelling.push_back(tdnd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic build_number();
      spelling.delete();
      if ($urandom_range(0, 2) == 0)
         spelling.push_back($urandom_range(0, 1) ? tdnd_pkg::CH_PLUS : tdnd_pkg::CH_MINUS);
      case ($urandom_range(0, 2))
         0: add_digits(1, 5);
         1: begin
            add_digits(0, 3);
            spelling.push_back(tdnd_pkg::CH_DOT);
            add_digits(1, 3);
         end
         default: begin
            add_digits(1, 3);
            spelling.push_back(tdnd_pkg::CH_DOT);
         end
      endcase
      if ($urandom_range(0, 2) == 0) begin
         spelling.push_back($urandom_range(0, 1) ? tdnd_pkg::CH_EXP_UP : tdnd_pkg::CH_EXP_LO);
         if ($urandom_range(0, 1))
            spelling.push_back($urandom_range(0, 1) ? tdnd_pkg::CH_PLUS : tdnd_pkg::CH_MINUS);
         add_digits(1, 3);
      end
   endtask

   task automatic build_random_text();
      spelling.delete();
      repeat ($urandom_range(1, 8))
         spelling.push_back(pick_char());
   endtask

   task automatic corrupt_spelling();
      int pos;
      pos = $urandom_range(0, spelling.size() - 1);
      case ($urandom_range(0, 2))
         0: spelling[pos] = pick_char();
         1: begin
            if (spelling.size() > 1)
               spelling.delete(pos);
            else
               spelling[pos] = pick_char();
         end
         default: spelling.insert(pos, pick_char());
      endcase
   endtask

   task automatic load_table(input bit number_style);
      for (int slot = 0; slot < TABLE_DEPTH; slot++) begin
         if (number_style && slot < NUMBER_ENTRIES)
            push_load(slot, number_entry(slot));
         else
            push_load(slot, random_entry(number_style ? 15 : 3));
      end
   endtask

   task automatic push_random_sequence(input bit number_style);
      int r;
      int cut;
      r = $urandom_range(0, 99);
      if (number_style)
         build_number();
      else
         build_random_text();
      if (r < 60) begin
         push_spelling(spelling.size(), 1'b1);
      end else if (r < 75) begin
         corrupt_spelling();
         push_spelling(spelling.size(), 1'b1);
      end else if (r < 83) begin
         build_random_text();
         push_spelling(spelling.size(), 1'b1);
      end else if (r < 88) begin
         push_empty();
      end else if (r < 93) begin
         push_spelling($urandom_range(1, spelling.size()), 1'b0);
         push_empty();
      end else if (r < 98) begin
         cut = $urandom_range(0, spelling.size() - 1);
         push_spelling(cut, 1'b0);
         if ($urandom_range(0, 2) == 0)
            push_noise();
         else if (number_style)
            push_load($urandom_range(NUMBER_ENTRIES, TABLE_DEPTH - 1), random_entry(15));
         else
            push_load($urandom_range(0, TABLE_DEPTH - 1), random_entry(3));
         push_spelling(spelling.size(), 1'b1);
      end else begin
         push_noise();
      end
   endtask

   task automatic program_registers(input logic [tdnd_pkg::STATE_W-1:0] start,
                                    input logic [tdnd_pkg::COUNT_W-1:0] count,
                                    input logic [tdnd_pkg::MASK_W-1:0] mask);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= tdnd_pkg::CSR_START_STATE;
      csr_wdata <= 16'(start);
      @(posedge clock);
      csr_index <= tdnd_pkg::CSR_TRANSITION_COUNT;
      csr_wdata <= 16'(count);
      @(posedge clock);
      csr_index <= tdnd_pkg::CSR_ACCEPT_MASK;
      csr_wdata <= mask;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_start = start;
      cfg_count = count;
      cfg_mask = mask;
      @(negedge clock);
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (pending.size() != 0 || req_valid || verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      bit                           number_style;
      bit                           table_is_number;
      int                           phase_end;
      logic [tdnd_pkg::STATE_W-1:0] start;
      logic [tdnd_pkg::COUNT_W-1:0] count;
      logic [tdnd_pkg::MASK_W-1:0]  mask;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      program_registers(4'd0, 6'd32, NUMBER_ACCEPT);
      load_table(1'b1);
      table_is_number = 1'b1;
      push_text("-.5e3", 1'b1);
      push_text("+9E-0", 1'b1);
      push_text("1e", 1'b1);
      push_text("1+", 1'b1);
      push_char("1", 1'b0);
      push_char(8'hFF, 1'b1);
      push_empty();
      push_text("12", 1'b0);
      push_empty();
      push_char("3", 1'b0);
      push_noise();
      push_load(TABLE_DEPTH - 1, {4'd4, tdnd_pkg::CH_PLUS, 4'd2});
      push_text(".5+7", 1'b1);
      drain();
      program_registers(4'd0, 6'd0, NUMBER_ACCEPT);
      push_text("5", 1'b1);
      drain();
      program_registers(4'd0, 6'd63, NUMBER_ACCEPT);
      push_text("7", 1'b1);
      drain();
      program_registers(4'd15, 6'd32, 16'h0000);
      push_text("1", 1'b1);
      drain();
      program_registers(4'd0, 6'd32, 16'hFFFF);
      push_text("1e", 1'b1);
      drain();

      while (words_queued < WORD_BUDGET) begin
         number_style = ($urandom_range(0, 3) != 0);
         if (number_style) begin
            start = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
            case ($urandom_range(0, 7))
               0:       count = 6'($urandom_range(0, 63));
               1:       count = 6'd63;
               2:       count = 6'($urandom_range(10, 20));
               default: count = 6'd32;
            endcase
            case ($urandom_range(0, 7))
               0:       mask = 16'($urandom);
               1:       mask = 16'hFFFF;
               2:       mask = 16'h0000;
               default: mask = NUMBER_ACCEPT;
            endcase
         end else begin
            start = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, 3));
            count = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(8, 32));
            mask = 16'($urandom);
         end
         calm = (words_queued >= WORD_BUDGET - CALM_WORDS);
         program_registers(start, count, mask);
         if (number_style != table_is_number || $urandom_range(0, 3) == 0)
            load_table(number_style);
         table_is_number = number_style;
         phase_end = words_queued + $urandom_range(40, 120);
         while (words_queued < phase_end)
            push_random_sequence(number_style);
         drain();
      end

      if (mismatches == 0)
         $display("table_driven_number_dfa_top verification clean");
      else
         $display("table_driven_number_dfa_top verification failed");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("table_driven_number_dfa_top verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/tdnd_pkg.sv
rtl/tdnd_front.sv
rtl/tdnd_back.sv
rtl/table_driven_number_dfa_top.sv
sim/tb.sv
